// ===== design/ema_background_subtract_map_macros.svh =====
// Assertion macros shared by the RTL of the background subtraction block.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef EMA_BACKGROUND_SUBTRACT_MAP_MACROS_SVH
`define EMA_BACKGROUND_SUBTRACT_MAP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define EBSM_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define EBSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ebsm_pkg.sv =====
// Package of the EMA background subtraction block: widths, types, register codes.
// No dependencies; used by the interfaces, the top level, ebsm_scale and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ebsm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAX_DOPPLER = 128;
   localparam int MAX_DELAY   = 256;

   localparam int ROW_W     = $clog2(MAX_DOPPLER);
   localparam int COL_W     = $clog2(MAX_DELAY);
   localparam int ROW_CNT_W = ROW_W + 1;
   localparam int COL_CNT_W = COL_W + 1;
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int CELLS     = 1 << ADDR_W;

   localparam int POWER_W    = 2 * SAMPLE_W;
   localparam int BG_FRAC    = 8;
   localparam int BG_W       = POWER_W + BG_FRAC;
   localparam int ALPHA_W    = 17;
   localparam int ALPHA_FRAC = 16;
   localparam int ALPHA_ONE  = 1 << ALPHA_FRAC;
   localparam int PROD_W     = (ALPHA_W + 1) + (BG_W + 1);

   localparam int SCALE_FRAC = 16;
   localparam int DIV_STEPS  = 2 * SCALE_FRAC;
   localparam int Q_W        = DIV_STEPS + 1;
   localparam int SQ_W       = Q_W + 1;
   localparam int SQRT_STEPS = SCALE_FRAC + 1;
   localparam int S_W        = SCALE_FRAC + 1;
   localparam int MAG_W      = SAMPLE_W + 1;
   localparam int MUL_W      = MAG_W + S_W + 1;

   localparam int WARM_W  = 16;
   localparam int DB_W    = 8;
   localparam int DL_W    = 9;
   localparam int CSR_W   = 17;
   localparam int MAPS_W  = 17;
   localparam logic [MAPS_W-1:0] MAPS_MAX = '1;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET  = ALPHA_W'(655);
   localparam logic [WARM_W-1:0]  WARM_RESET   = WARM_W'(10);
   localparam logic [DB_W-1:0]    DOPPLER_RESET = DB_W'(128);
   localparam logic [DL_W-1:0]    DELAY_RESET  = DL_W'(256);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type re;
      sample_type im;
   } cell_type;

   // Per-word control that travels down the pipeline.
   typedef struct packed {
      logic warm;
      logic zero;
      logic eom;
   } ctl_type;

   typedef enum logic [1:0] {
      CSR_ALPHA,
      CSR_WARMUP,
      CSR_DOPPLER,
      CSR_DELAY
   } csr_index_type;

endpackage

`default_nettype wire

// ===== design/ebsm_if.sv =====
// Valid/ready channel interfaces of the EMA background subtraction block.
// Depends on ebsm_pkg for the sample type.
`timescale 1ns / 1ps
`default_nettype none

interface ebsm_req_if;
   logic                 valid;
   logic                 ready;
   ebsm_pkg::sample_type sample_re;
   ebsm_pkg::sample_type sample_im;
   modport source (output valid, output sample_re, output sample_im, input ready);
   modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

interface ebsm_rsp_if;
   logic                 valid;
   logic                 ready;
   ebsm_pkg::sample_type result_re;
   ebsm_pkg::sample_type result_im;
   logic                 end_of_map;
   modport source (output valid, output result_re, output result_im, output end_of_map,
                   input ready);
   modport sink (input valid, input result_re, input result_im, input end_of_map,
                 output ready);
endinterface

`default_nettype wire

// ===== design/ema_background_subtract_map.sv =====
// EMA background subtraction over a streamed delay-Doppler map.
//
// Words enter on req_bus (sample_re, sample_im) in row order and leave on
// rsp_bus (result_re, result_im, end_of_map), one result per input word, in
// order. Both channels move a word at a clock edge where valid and ready are
// both high. Geometry, EMA weight and warmup length are written through the
// csr_ port; the user must write them only while the block is idle, which the
// block itself does not enforce. One word is accepted per cycle unless stalled.
// The background store is read as a word is accepted and rewritten from stage 4,
// so a word whose cell is still being updated waits; this only happens for maps
// of fewer than five cells. After reset the background store is cleared one
// entry per cycle, over all 32768 entries; req_bus.ready stays low meanwhile,
// configuration writes are taken. When the receiver holds rsp_bus.ready low
// while a result is offered, the whole pipeline freezes and input is
// back-pressured; nothing is lost or repeated.
// Depends on ebsm_pkg, ebsm_if, ebsm_ram, ebsm_scale and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ema_background_subtract_map_macros.svh"

module ema_background_subtract_map (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ebsm_req_if.sink                            req_bus,
   ebsm_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_we,
   input  wire ebsm_pkg::csr_index_type        csr_index,
   input  wire logic [ebsm_pkg::CSR_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [ebsm_pkg::ALPHA_W-1:0] alpha_ff;
   logic [ebsm_pkg::WARM_W-1:0]  warm_ff;
   logic [ebsm_pkg::DB_W-1:0]    doppler_ff;
   logic [ebsm_pkg::DL_W-1:0]    delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= ebsm_pkg::ALPHA_RESET;
         warm_ff    <= ebsm_pkg::WARM_RESET;
         doppler_ff <= ebsm_pkg::DOPPLER_RESET;
         delay_ff   <= ebsm_pkg::DELAY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ebsm_pkg::CSR_ALPHA:   alpha_ff   <= csr_wdata[ebsm_pkg::ALPHA_W-1:0];
            ebsm_pkg::CSR_WARMUP:  warm_ff    <= csr_wdata[ebsm_pkg::WARM_W-1:0];
            ebsm_pkg::CSR_DOPPLER: doppler_ff <= csr_wdata[ebsm_pkg::DB_W-1:0];
            ebsm_pkg::CSR_DELAY:   delay_ff   <= csr_wdata[ebsm_pkg::DL_W-1:0];
         endcase
      end
   end

   // Clearing pass over the background store after reset.
   logic                        clr_busy_ff, clr_busy_in;
   logic [ebsm_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ebsm_pkg::ADDR_W'(1);
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Position counters and completed map count.
   logic [ebsm_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [ebsm_pkg::COL_W-1:0]     col_ff, col_in;
   logic [ebsm_pkg::MAPS_W-1:0]    maps_ff, maps_in;
   logic [ebsm_pkg::ROW_CNT_W-1:0] rows_eff;
   logic [ebsm_pkg::COL_CNT_W-1:0] cols_eff;
   logic [ebsm_pkg::ALPHA_W-1:0]   alpha_eff;
   logic                           col_last, row_last, eom_cur, warm_cur;
   logic [ebsm_pkg::ADDR_W-1:0]    addr_cur;

   logic [4:0]                     pipe_v_ff;
   logic                           adv, hazard, req_accept;

   always_comb begin
      if (doppler_ff == '0) begin
         rows_eff = ebsm_pkg::ROW_CNT_W'(1);
      end else if (32'(doppler_ff) > ebsm_pkg::MAX_DOPPLER) begin
         rows_eff = ebsm_pkg::ROW_CNT_W'(ebsm_pkg::MAX_DOPPLER);
      end else begin
         rows_eff = ebsm_pkg::ROW_CNT_W'(doppler_ff);
      end
      if (delay_ff == '0) begin
         cols_eff = ebsm_pkg::COL_CNT_W'(1);
      end else if (32'(delay_ff) > ebsm_pkg::MAX_DELAY) begin
         cols_eff = ebsm_pkg::COL_CNT_W'(ebsm_pkg::MAX_DELAY);
      end else begin
         cols_eff = ebsm_pkg::COL_CNT_W'(delay_ff);
      end
      alpha_eff = (32'(alpha_ff) > ebsm_pkg::ALPHA_ONE)
                  ? ebsm_pkg::ALPHA_W'(ebsm_pkg::ALPHA_ONE) : alpha_ff;

      col_last = ({1'b0, col_ff} + ebsm_pkg::COL_CNT_W'(1)) >= cols_eff;
      row_last = ({1'b0, row_ff} + ebsm_pkg::ROW_CNT_W'(1)) >= rows_eff;
      eom_cur  = col_last && row_last;
      warm_cur = maps_ff >= ebsm_pkg::MAPS_W'(warm_ff);
      addr_cur = {row_ff, col_ff};

      row_in  = row_ff;
      col_in  = col_ff;
      maps_in = maps_ff;
      if (req_accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in = '0;
               if (maps_ff != ebsm_pkg::MAPS_MAX) begin
                  maps_in = maps_ff + ebsm_pkg::MAPS_W'(1);
               end
            end else begin
               row_in = row_ff + ebsm_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + ebsm_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         maps_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         maps_ff <= maps_in;
      end
   end

   // Pipeline stage registers (stage 1 background comes from the RAM output).
   ebsm_pkg::cell_type            s1_cell_ff, s2_cell_ff, s3_cell_ff, s4_cell_ff, s5_cell_ff;
   ebsm_pkg::ctl_type             s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff;
   ebsm_pkg::ctl_type             s3_ctl_in;
   logic [ebsm_pkg::ALPHA_W-1:0]  s1_alpha_ff, s2_alpha_ff;
   logic [ebsm_pkg::ADDR_W-1:0]   s1_addr_ff, s2_addr_ff, s3_addr_ff, s4_addr_ff;
   logic [ebsm_pkg::BG_W-1:0]     ram_q;
   logic [ebsm_pkg::BG_W-1:0]     s2_bg_ff, s3_bg_ff, s4_bg_ff, s4_bg_in;
   logic [ebsm_pkg::POWER_W-1:0]  s2_power_ff, s2_power_in;
   logic [ebsm_pkg::BG_W-1:0]     s3_p8_ff, s3_p8_in, s4_p8_ff, s5_den_ff;
   logic [ebsm_pkg::BG_W-1:0]     s5_num_ff, s5_num_in;
   logic signed [ebsm_pkg::PROD_W-1:0]  s3_prod_ff, s3_prod_in, prod_rnd;
   logic signed [ebsm_pkg::POWER_W-1:0] sq_re, sq_im;
   logic signed [ebsm_pkg::BG_W:0]      delta;

   assign adv        = !rsp_bus.valid || rsp_bus.ready;
   assign hazard     = (pipe_v_ff[0] && (s1_addr_ff == addr_cur))
                    || (pipe_v_ff[1] && (s2_addr_ff == addr_cur))
                    || (pipe_v_ff[2] && (s3_addr_ff == addr_cur))
                    || (pipe_v_ff[3] && (s4_addr_ff == addr_cur));
   assign req_bus.ready = adv && !clr_busy_ff && !hazard;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      sq_re       = ebsm_pkg::POWER_W'(s1_cell_ff.re) * ebsm_pkg::POWER_W'(s1_cell_ff.re);
      sq_im       = ebsm_pkg::POWER_W'(s1_cell_ff.im) * ebsm_pkg::POWER_W'(s1_cell_ff.im);
      s2_power_in = unsigned'(sq_re) + unsigned'(sq_im);

      // bg + a * (p8 - bg) / 2^16 equals the weighted sum of the two terms.
      s3_p8_in   = {s2_power_ff, ebsm_pkg::BG_FRAC'(0)};
      delta      = signed'({1'b0, s3_p8_in}) - signed'({1'b0, s2_bg_ff});
      s3_prod_in = ebsm_pkg::PROD_W'(signed'({1'b0, s2_alpha_ff}))
                   * ebsm_pkg::PROD_W'(delta);
      s3_ctl_in      = s2_ctl_ff;
      s3_ctl_in.zero = (s2_power_ff == '0);

      prod_rnd = s3_prod_ff + ebsm_pkg::PROD_W'(1 << (ebsm_pkg::ALPHA_FRAC - 1));
      s4_bg_in = s3_bg_ff + prod_rnd[ebsm_pkg::ALPHA_FRAC +: ebsm_pkg::BG_W];

      s5_num_in = (s4_p8_ff > s4_bg_ff) ? (s4_p8_ff - s4_bg_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
      end else if (adv) begin
         pipe_v_ff <= {pipe_v_ff[3:0], req_accept};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cell_ff.re <= req_bus.sample_re;
         s1_cell_ff.im <= req_bus.sample_im;
         s1_ctl_ff     <= '{warm: warm_cur, zero: 1'b0, eom: eom_cur};
         s1_alpha_ff   <= alpha_eff;
         s1_addr_ff    <= addr_cur;

         s2_cell_ff  <= s1_cell_ff;
         s2_ctl_ff   <= s1_ctl_ff;
         s2_alpha_ff <= s1_alpha_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_bg_ff    <= ram_q;
         s2_power_ff <= s2_power_in;

         s3_cell_ff <= s2_cell_ff;
         s3_ctl_ff  <= s3_ctl_in;
         s3_addr_ff <= s2_addr_ff;
         s3_bg_ff   <= s2_bg_ff;
         s3_p8_ff   <= s3_p8_in;
         s3_prod_ff <= s3_prod_in;

         s4_cell_ff <= s3_cell_ff;
         s4_ctl_ff  <= s3_ctl_ff;
         s4_addr_ff <= s3_addr_ff;
         s4_bg_ff   <= s4_bg_in;
         s4_p8_ff   <= s3_p8_ff;

         s5_cell_ff <= s4_cell_ff;
         s5_ctl_ff  <= s4_ctl_ff;
         s5_num_ff  <= s5_num_in;
         s5_den_ff  <= s4_p8_ff;
      end
   end

   logic                        ram_we;
   logic [ebsm_pkg::ADDR_W-1:0] ram_waddr;
   logic [ebsm_pkg::BG_W-1:0]   ram_wdata;

   // Stage 4 writes back as it advances; the clearing pass owns the port first.
   always_comb begin
      ram_we    = clr_busy_ff || (pipe_v_ff[3] && adv);
      ram_waddr = clr_busy_ff ? clr_addr_ff : s4_addr_ff;
      ram_wdata = clr_busy_ff ? '0 : s4_bg_ff;
   end

   ebsm_ram #(
      .WIDTH (ebsm_pkg::BG_W),
      .DEPTH (ebsm_pkg::CELLS)
   ) u_bg_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (adv),
      .rd_addr (addr_cur),
      .rd_data (ram_q)
   );

   ebsm_pkg::cell_type out_cell;
   logic               out_valid, out_eom;

   ebsm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pipe_v_ff[4]),
      .in_cell   (s5_cell_ff),
      .in_ctl    (s5_ctl_ff),
      .in_num    (s5_num_ff),
      .in_den    (s5_den_ff),
      .out_valid (out_valid),
      .out_cell  (out_cell),
      .out_eom   (out_eom)
   );

   assign rsp_bus.valid      = out_valid;
   assign rsp_bus.result_re  = out_cell.re;
   assign rsp_bus.result_im  = out_cell.im;
   assign rsp_bus.end_of_map = out_eom;

   `EBSM_ASSERT_NOW(a_no_rmw_overlap, !(req_accept && pipe_v_ff[3]) || (addr_cur != s4_addr_ff), "read of a cell whose update is still in flight")
   `EBSM_ASSERT_NOW(a_clear_empty, !clr_busy_ff || ((pipe_v_ff == '0) && !rsp_bus.valid), "words in flight during the clearing pass")
   `EBSM_ASSERT_NEXT(a_maps_count, req_accept && eom_cur && (maps_ff != ebsm_pkg::MAPS_MAX), maps_ff == $past(maps_ff) + ebsm_pkg::MAPS_W'(1), "map count did not advance at end of map")

endmodule

`default_nettype wire

// ===== design/ebsm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ebsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when both ports hit the same entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/ebsm_scale.sv =====
// Residual scale pipeline: bit-per-stage ratio divider, bit-per-stage square root,
// then magnitude scaling with rounding. Depends on ebsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ebsm_scale (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire ebsm_pkg::cell_type            in_cell,
   input  wire ebsm_pkg::ctl_type             in_ctl,
   input  wire logic [ebsm_pkg::BG_W-1:0]     in_num,
   input  wire logic [ebsm_pkg::BG_W-1:0]     in_den,
   output logic                               out_valid,
   output ebsm_pkg::cell_type                 out_cell,
   output logic                               out_eom
);

   // Divider stages: stage 0 takes the integer bit, stages 1..DIV_STEPS a fraction bit.
   logic [ebsm_pkg::DIV_STEPS:0] dv_v_ff;
   logic [ebsm_pkg::BG_W-1:0]    dv_r_ff   [ebsm_pkg::DIV_STEPS+1];
   logic [ebsm_pkg::BG_W-1:0]    dv_d_ff   [ebsm_pkg::DIV_STEPS+1];
   logic [ebsm_pkg::Q_W-1:0]     dv_q_ff   [ebsm_pkg::DIV_STEPS+1];
   ebsm_pkg::cell_type           dv_cell_ff[ebsm_pkg::DIV_STEPS+1];
   ebsm_pkg::ctl_type            dv_ctl_ff [ebsm_pkg::DIV_STEPS+1];

   // Square root stages, one result bit each.
   logic [ebsm_pkg::SQRT_STEPS-1:0] sq_v_ff;
   logic [ebsm_pkg::SQ_W-1:0]       sq_x_ff   [ebsm_pkg::SQRT_STEPS];
   logic [ebsm_pkg::SQ_W-1:0]       sq_r_ff   [ebsm_pkg::SQRT_STEPS];
   ebsm_pkg::cell_type              sq_cell_ff[ebsm_pkg::SQRT_STEPS];
   ebsm_pkg::ctl_type               sq_ctl_ff [ebsm_pkg::SQRT_STEPS];

   logic                        mul_v_ff;
   logic [ebsm_pkg::MUL_W-1:0]  mul_re_ff, mul_re_in;
   logic [ebsm_pkg::MUL_W-1:0]  mul_im_ff, mul_im_in;
   ebsm_pkg::cell_type          mul_cell_ff;
   ebsm_pkg::ctl_type           mul_ctl_ff;

   logic                        out_v_ff;
   ebsm_pkg::cell_type          out_cell_ff, out_cell_in;
   logic                        out_eom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff  <= '0;
         sq_v_ff  <= '0;
         mul_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         dv_v_ff  <= {dv_v_ff[ebsm_pkg::DIV_STEPS-1:0], in_valid};
         sq_v_ff  <= {sq_v_ff[ebsm_pkg::SQRT_STEPS-2:0], dv_v_ff[ebsm_pkg::DIV_STEPS]};
         mul_v_ff <= sq_v_ff[ebsm_pkg::SQRT_STEPS-1];
         out_v_ff <= mul_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (in_num >= in_den) begin
            dv_r_ff[0] <= in_num - in_den;
            dv_q_ff[0] <= ebsm_pkg::Q_W'(1);
         end else begin
            dv_r_ff[0] <= in_num;
            dv_q_ff[0] <= '0;
         end
         dv_d_ff[0]    <= in_den;
         dv_cell_ff[0] <= in_cell;
         dv_ctl_ff[0]  <= in_ctl;
      end
   end

   for (genvar k = 1; k <= ebsm_pkg::DIV_STEPS; k++) begin : g_div
      logic [ebsm_pkg::BG_W:0]   shifted;
      logic [ebsm_pkg::BG_W:0]   diff;
      logic                      take;
      logic [ebsm_pkg::BG_W-1:0] r_in;

      always_comb begin
         shifted = {dv_r_ff[k-1], 1'b0};
         diff    = shifted - {1'b0, dv_d_ff[k-1]};
         take    = shifted >= {1'b0, dv_d_ff[k-1]};
         r_in    = take ? diff[ebsm_pkg::BG_W-1:0] : shifted[ebsm_pkg::BG_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_r_ff[k]    <= r_in;
            dv_q_ff[k]    <= {dv_q_ff[k-1][ebsm_pkg::Q_W-2:0], take};
            dv_d_ff[k]    <= dv_d_ff[k-1];
            dv_cell_ff[k] <= dv_cell_ff[k-1];
            dv_ctl_ff[k]  <= dv_ctl_ff[k-1];
         end
      end
   end

   for (genvar j = 0; j < ebsm_pkg::SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [ebsm_pkg::SQ_W-1:0] BIT =
         ebsm_pkg::SQ_W'(1) << (2 * (ebsm_pkg::SQRT_STEPS - 1 - j));
      logic [ebsm_pkg::SQ_W-1:0] x_prev, r_prev, trial, x_in, r_in;
      ebsm_pkg::cell_type        cell_prev;
      ebsm_pkg::ctl_type         ctl_prev;

      if (j == 0) begin : g_first
         assign x_prev    = ebsm_pkg::SQ_W'(dv_q_ff[ebsm_pkg::DIV_STEPS]);
         assign r_prev    = '0;
         assign cell_prev = dv_cell_ff[ebsm_pkg::DIV_STEPS];
         assign ctl_prev  = dv_ctl_ff[ebsm_pkg::DIV_STEPS];
      end else begin : g_rest
         assign x_prev    = sq_x_ff[j-1];
         assign r_prev    = sq_r_ff[j-1];
         assign cell_prev = sq_cell_ff[j-1];
         assign ctl_prev  = sq_ctl_ff[j-1];
      end

      always_comb begin
         trial = r_prev + BIT;
         if (x_prev >= trial) begin
            x_in = x_prev - trial;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            x_in = x_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_x_ff[j]    <= x_in;
            sq_r_ff[j]    <= r_in;
            sq_cell_ff[j] <= cell_prev;
            sq_ctl_ff[j]  <= ctl_prev;
         end
      end
   end

   ebsm_pkg::cell_type             last_cell;
   logic [ebsm_pkg::S_W-1:0]       scale;
   logic [ebsm_pkg::MAG_W-1:0]     mag_re, mag_im;

   always_comb begin
      last_cell = sq_cell_ff[ebsm_pkg::SQRT_STEPS-1];
      scale     = sq_r_ff[ebsm_pkg::SQRT_STEPS-1][ebsm_pkg::S_W-1:0];
      mag_re    = last_cell.re[ebsm_pkg::SAMPLE_W-1]
                  ? ebsm_pkg::MAG_W'(-ebsm_pkg::MAG_W'(last_cell.re))
                  : ebsm_pkg::MAG_W'(last_cell.re);
      mag_im    = last_cell.im[ebsm_pkg::SAMPLE_W-1]
                  ? ebsm_pkg::MAG_W'(-ebsm_pkg::MAG_W'(last_cell.im))
                  : ebsm_pkg::MAG_W'(last_cell.im);
      mul_re_in = ebsm_pkg::MUL_W'(mag_re) * ebsm_pkg::MUL_W'(scale);
      mul_im_in = ebsm_pkg::MUL_W'(mag_im) * ebsm_pkg::MUL_W'(scale);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_re_ff   <= mul_re_in;
         mul_im_ff   <= mul_im_in;
         mul_cell_ff <= last_cell;
         mul_ctl_ff  <= sq_ctl_ff[ebsm_pkg::SQRT_STEPS-1];
      end
   end

   logic [ebsm_pkg::MUL_W-1:0]    rnd_re, rnd_im;
   logic [ebsm_pkg::MAG_W-1:0]    val_re, val_im;
   ebsm_pkg::sample_type          sc_re, sc_im;

   // Round half away from zero on the magnitude, then restore the sign.
   always_comb begin
      rnd_re = mul_re_ff + ebsm_pkg::MUL_W'(1 << (ebsm_pkg::SCALE_FRAC - 1));
      rnd_im = mul_im_ff + ebsm_pkg::MUL_W'(1 << (ebsm_pkg::SCALE_FRAC - 1));
      val_re = rnd_re[ebsm_pkg::SCALE_FRAC +: ebsm_pkg::MAG_W];
      val_im = rnd_im[ebsm_pkg::SCALE_FRAC +: ebsm_pkg::MAG_W];
      sc_re  = mul_cell_ff.re[ebsm_pkg::SAMPLE_W-1]
               ? ebsm_pkg::sample_type'(-val_re) : ebsm_pkg::sample_type'(val_re);
      sc_im  = mul_cell_ff.im[ebsm_pkg::SAMPLE_W-1]
               ? ebsm_pkg::sample_type'(-val_im) : ebsm_pkg::sample_type'(val_im);
      if (!mul_ctl_ff.warm) begin
         out_cell_in = mul_cell_ff;
      end else if (mul_ctl_ff.zero) begin
         out_cell_in = '0;
      end else begin
         out_cell_in.re = sc_re;
         out_cell_in.im = sc_im;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_cell_ff <= out_cell_in;
         out_eom_ff  <= mul_ctl_ff.eom;
      end
   end

   assign out_valid = out_v_ff;
   assign out_cell  = out_cell_ff;
   assign out_eom   = out_eom_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of ema_background_subtract_map: directed and random map words.
// Depends on ebsm_pkg and the ebsm_req_if / ebsm_rsp_if interfaces of the design.
`timescale 1ns / 1ps

module tb;

   typedef struct {
      ebsm_pkg::sample_type re;
      ebsm_pkg::sample_type im;
      logic                 eom;
   } map_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   ebsm_pkg::csr_index_type csr_index;
   logic [ebsm_pkg::CSR_W-1:0] csr_wdata;

   ebsm_req_if req_bus ();
   ebsm_rsp_if rsp_bus ();

   ema_background_subtract_map u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Copy of the block state kept by the checker.
   logic [ebsm_pkg::BG_W-1:0] bg_power [0:ebsm_pkg::CELLS-1];
   int unsigned cur_row, cur_col, maps_done;
   int unsigned alpha_cfg, warmup_cfg, doppler_cfg, delay_cfg;

   ebsm_pkg::cell_type   word_queue[$];
   map_result_type       result_queue[$];
   int                   fail_count;
   int                   words_checked;
   bit                   idle_on;
   bit                   pressure_armed;
   bit                   pressure_done;
   int                   send_gap;
   int                   stall_left;
   ebsm_pkg::sample_type clutter_re [0:31];
   ebsm_pkg::sample_type clutter_im [0:31];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // floor(num * 2^32 / den) by restoring division, num <= den.
   function automatic longint unsigned ratio_q32(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = num;
      if (r >= den) begin
         q = 1;
         r = r - den;
      end
      for (int k = 0; k < 32; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function automatic ebsm_pkg::sample_type scale_part(longint signed x, longint unsigned s);
      longint unsigned m, v;
      m = (x < 0) ? longint'(-x) : longint'(x);
      v = (m * s + 32768) >> 16;
      return (x < 0) ? ebsm_pkg::sample_type'(-longint'(v)) : ebsm_pkg::sample_type'(v);
   endfunction

   // Updates the background of the current cell and queues the expected result.
   function automatic void predict_cell(ebsm_pkg::sample_type re, ebsm_pkg::sample_type im);
      longint signed sre, sim;
      longint unsigned a, na, p, p8, bg, hi, lo, r8, s;
      int unsigned rows, cols, addr;
      map_result_type res;
      sre = re;
      sim = im;
      a = (alpha_cfg > ebsm_pkg::ALPHA_ONE) ? ebsm_pkg::ALPHA_ONE : alpha_cfg;
      na = ebsm_pkg::ALPHA_ONE - a;
      rows = (doppler_cfg == 0) ? 1 : (doppler_cfg > ebsm_pkg::MAX_DOPPLER
                                       ? ebsm_pkg::MAX_DOPPLER : doppler_cfg);
      cols = (delay_cfg == 0) ? 1 : (delay_cfg > ebsm_pkg::MAX_DELAY
                                     ? ebsm_pkg::MAX_DELAY : delay_cfg);
      addr = cur_row * ebsm_pkg::MAX_DELAY + cur_col;
      if (addr >= ebsm_pkg::CELLS) addr = 0;
      p = sre * sre + sim * sim;
      p8 = p << 8;
      bg = bg_power[addr];
      hi = na * (bg >> 16) + a * (p8 >> 16);
      lo = na * (bg & 64'hFFFF) + a * (p8 & 64'hFFFF) + 32768;
      bg = hi + (lo >> 16);
      bg_power[addr] = bg[ebsm_pkg::BG_W-1:0];
      res.re = re;
      res.im = im;
      res.eom = 1'b0;
      if (maps_done >= warmup_cfg) begin
         if (p == 0) begin
            res.re = '0;
            res.im = '0;
         end else begin
            r8 = (p8 > bg) ? p8 - bg : 0;
            s = int_sqrt(ratio_q32(r8, p8));
            res.re = scale_part(sre, s);
            res.im = scale_part(sim, s);
         end
      end
      if (cur_col + 1 >= cols) begin
         cur_col = 0;
         if (cur_row + 1 >= rows) begin
            cur_row = 0;
            res.eom = 1'b1;
            if (maps_done < ebsm_pkg::MAPS_MAX) maps_done++;
         end else begin
            cur_row++;
         end
      end else begin
         cur_col++;
      end
      result_queue.push_back(res);
   endfunction

   // Driver of the input channel.
   always @(posedge clock) begin
      ebsm_pkg::cell_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (word_queue.size() > 0) begin
            w = word_queue.pop_front();
            req_bus.sample_re <= w.re;
            req_bus.sample_im <= w.im;
            req_bus.valid <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver ready with random stalls and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (pressure_armed && !pressure_done) begin
         pressure_done = 1'b1;
         stall_left = 300;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: predicts on input acceptance, checks on result acceptance.
   always @(posedge clock) begin
      map_result_type exp_res;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) predict_cell(req_bus.sample_re, req_bus.sample_im);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (result_queue.size() == 0) begin
               $error("unexpected result word re=%0d im=%0d", rsp_bus.result_re,
                      rsp_bus.result_im);
               fail_count++;
            end else begin
               exp_res = result_queue.pop_front();
               words_checked++;
               if (rsp_bus.result_re !== exp_res.re) begin
                  $error("result_re expected %0d actual %0d", exp_res.re, rsp_bus.result_re);
                  fail_count++;
               end
               if (rsp_bus.result_im !== exp_res.im) begin
                  $error("result_im expected %0d actual %0d", exp_res.im, rsp_bus.result_im);
                  fail_count++;
               end
               if (rsp_bus.end_of_map !== exp_res.eom) begin
                  $error("end_of_map expected %0b actual %0b", exp_res.eom,
                         rsp_bus.end_of_map);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic write_reg(ebsm_pkg::csr_index_type idx, int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= ebsm_pkg::CSR_W'(value);
      case (idx)
         ebsm_pkg::CSR_ALPHA:   alpha_cfg = value & 32'h1FFFF;
         ebsm_pkg::CSR_WARMUP:  warmup_cfg = value & 32'hFFFF;
         ebsm_pkg::CSR_DOPPLER: doppler_cfg = value & 32'hFF;
         ebsm_pkg::CSR_DELAY:   delay_cfg = value & 32'h1FF;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Sampled away from the rising edge so that the driver has settled.
   task automatic wait_idle();
      @(negedge clock);
      while (word_queue.size() != 0 || req_bus.valid || result_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic add_word(int re, int im);
      ebsm_pkg::cell_type w;
      w.re = ebsm_pkg::sample_type'(re);
      w.im = ebsm_pkg::sample_type'(im);
      word_queue.push_back(w);
   endtask

   // Mostly a steady clutter pattern per map position, with noise and some targets.
   task automatic add_random_maps(int n, int map_cells);
      int k, sel;
      for (int i = 0; i < n; i++) begin
         k = i % map_cells % 32;
         sel = $urandom_range(0, 9);
         if (sel < 7)
            add_word(clutter_re[k] + $urandom_range(0, 512) - 256,
                     clutter_im[k] + $urandom_range(0, 512) - 256);
         else if (sel < 8)
            add_word(clutter_re[k] / 2 + $urandom_range(0, 24000) - 12000,
                     clutter_im[k] / 2 + $urandom_range(0, 24000) - 12000);
         else
            add_word($urandom, $urandom);
      end
   endtask

   initial begin
      int rows, cols;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = ebsm_pkg::CSR_ALPHA;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.sample_re = '0;
      req_bus.sample_im = '0;
      rsp_bus.ready = 1'b0;
      idle_on = 1'b1;
      pressure_armed = 1'b0;
      pressure_done = 1'b0;
      fail_count = 0;
      words_checked = 0;
      for (int i = 0; i < ebsm_pkg::CELLS; i++) bg_power[i] = '0;
      cur_row = 0;
      cur_col = 0;
      maps_done = 0;
      alpha_cfg = ebsm_pkg::ALPHA_RESET;
      warmup_cfg = ebsm_pkg::WARM_RESET;
      doppler_cfg = ebsm_pkg::DOPPLER_RESET;
      delay_cfg = ebsm_pkg::DELAY_RESET;
      for (int i = 0; i < 32; i++) begin
         clutter_re[i] = ebsm_pkg::sample_type'($urandom_range(0, 40000) - 20000);
         clutter_im[i] = ebsm_pkg::sample_type'($urandom_range(0, 40000) - 20000);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: still in warmup, so every word passes through.
      add_word(-32768, -32768);
      add_word(32767, 32767);
      add_word(0, 0);
      add_word(-32768, 32767);
      add_word(32767, -32768);
      add_word(-1, 1);
      add_word(16'h5555, 16'hAAAA);
      add_word(16'hAAAA, 16'h5555);
      wait_idle();

      // Single-cell maps, alpha of one, no warmup: background follows the input.
      write_reg(ebsm_pkg::CSR_ALPHA, 65536);
      write_reg(ebsm_pkg::CSR_WARMUP, 0);
      write_reg(ebsm_pkg::CSR_DOPPLER, 1);
      write_reg(ebsm_pkg::CSR_DELAY, 1);
      add_word(3, 4);
      add_word(0, 0);
      add_word(-32768, -32768);
      add_word(32767, -1);
      wait_idle();

      // Alpha of zero freezes the background; strong targets over it.
      write_reg(ebsm_pkg::CSR_ALPHA, 0);
      add_word(1000, -1000);
      add_word(-32768, 32767);
      add_word(1, 0);
      wait_idle();

      // Out-of-range settings: alpha above one, zero-sized and oversized maps, long warmup.
      write_reg(ebsm_pkg::CSR_ALPHA, 131071);
      write_reg(ebsm_pkg::CSR_DOPPLER, 0);
      write_reg(ebsm_pkg::CSR_DELAY, 0);
      write_reg(ebsm_pkg::CSR_WARMUP, 65535);
      add_word(200, 300);
      add_word(-5, 7);
      wait_idle();
      write_reg(ebsm_pkg::CSR_DOPPLER, 255);
      write_reg(ebsm_pkg::CSR_DELAY, 511);
      add_word(12345, -12345);
      add_word(0, 0);
      wait_idle();

      // Random phases with small maps so that many maps complete.
      for (int ph = 0; ph < 4; ph++) begin
         rows = $urandom_range(1, 4);
         cols = $urandom_range(1, 8);
         write_reg(ebsm_pkg::CSR_DOPPLER, rows);
         write_reg(ebsm_pkg::CSR_DELAY, cols);
         write_reg(ebsm_pkg::CSR_ALPHA, (ph == 0) ? 32768 : $urandom_range(0, 65536));
         write_reg(ebsm_pkg::CSR_WARMUP, maps_done + $urandom_range(0, 3));
         if (ph == 3) idle_on = 1'b0;
         add_random_maps(110, rows * cols);
         if (ph == 0) pressure_armed = 1'b1;
         wait_idle();
      end

      repeat (100) @(posedge clock);
      $display("Checked %0d result words over %0d completed maps, including warmup,",
               words_checked, maps_done);
      $display("zero-power cells, out-of-range settings and a long receiver hold-off.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
